/* rtl/lmqs_pkg.sv */
package lmqs_pkg;

   localparam int LINES_PER_REGISTER = 16;
   localparam int LINE_W             = 4;

   // item modes
   localparam logic MODE_WRITE   = 1'b0;
   localparam logic MODE_REFRESH = 1'b1;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_ROWS = 1'b0;
   localparam logic CSR_IDX_COLS = 1'b1;
   localparam int   CSR_ADDR_W   = 3;
   localparam int   CSR_DATA_W   = 32;

   typedef struct packed {
      logic        mode;
      logic        panel_row;
      logic [1:0]  register_index;
      logic [3:0]  line_index;
      logic [15:0] pixel_word;
   } req_type;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       last;
      logic [1:0] row_select;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic start;
      logic write;
      logic issue;
   } ctl_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic last_issue;
   } dp_status_type;

endpackage

/* rtl/lmqs_csr.sv */
module lmqs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lmqs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lmqs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lmqs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [1:0]                        rows_cfg,
   output logic [1:0]                        cols_cfg
);
   import lmqs_pkg::*;

   logic [1:0] rows_ff, rows_in;
   logic [1:0] cols_ff, cols_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            CSR_IDX_ROWS: rows_in = csr_pwdata[1:0];
            CSR_IDX_COLS: cols_in = csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 2'd1;
         cols_ff <= 2'd1;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_ROWS: csr_prdata = {{(CSR_DATA_W-2){1'b0}}, rows_ff};
         CSR_IDX_COLS: csr_prdata = {{(CSR_DATA_W-2){1'b0}}, cols_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign rows_cfg = rows_ff;
   assign cols_cfg = cols_ff;

endmodule

/* rtl/lmqs_ctrl.sv */
module lmqs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_mode,
   output logic                    req_stall,
   input  lmqs_pkg::dp_status_type status,
   output lmqs_pkg::ctl_cmd_type   cmd
);
   import lmqs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_mode == MODE_REFRESH) begin
                  cmd.start = 1'b1;
                  state_in  = ST_RUN;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_RUN: begin
            // one memory read per free slot in the read stage
            cmd.issue = status.slot_free;
            if (status.slot_free && status.last_issue) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* rtl/lmqs_datapath.sv */
module lmqs_datapath #(
   parameter int MAX_PANEL_ROWS = 2,
   parameter int MAX_PANEL_COLS = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lmqs_pkg::req_type       req_data,
   input  lmqs_pkg::ctl_cmd_type   cmd,
   output lmqs_pkg::dp_status_type status,
   input  logic [1:0]              rows_cfg,
   input  logic [1:0]              cols_cfg,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output lmqs_pkg::rsp_type       rsp_data
);
   import lmqs_pkg::*;

   localparam int REGS_PER_ROW = MAX_PANEL_COLS * 2;
   localparam int MEM_WORDS    = MAX_PANEL_ROWS * REGS_PER_ROW * LINES_PER_REGISTER;
   localparam int ADDR_W       = $clog2(MEM_WORDS);
   localparam int ROW_W        = (MAX_PANEL_ROWS > 1) ? $clog2(MAX_PANEL_ROWS) : 1;
   localparam int REG_W        = $clog2(REGS_PER_ROW);

   logic [15:0]          mem [MEM_WORDS];
   logic [MEM_WORDS-1:0] valid_ff, valid_in;

   logic [1:0]       phase_ff, phase_in;
   logic [1:0]       k_ff, k_in;
   logic             half_ff, half_in;
   logic [REG_W-1:0] j_ff, j_in;
   logic [ROW_W-1:0] n_ff, n_in;

   logic [15:0] s1_word_ff;
   logic        s1_ok_ff;
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_half_ff;
   logic        s1_last_ff;
   logic [1:0]  s1_phase_ff;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;

   logic [1:0]        rows_eff;
   logic [1:0]        cols_eff;
   logic [2:0]        regs_eff;
   logic              last_k, last_j, last_n, last_issue;
   logic              s1_move, slot_free;
   logic              wr_ok;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        s1_byte;

   // register values outside the range are clamped
   always_comb begin
      if (rows_cfg == 2'd0)                      rows_eff = 2'd1;
      else if (int'(rows_cfg) > MAX_PANEL_ROWS)  rows_eff = 2'(MAX_PANEL_ROWS);
      else                                       rows_eff = rows_cfg;
      if (cols_cfg == 2'd0)                      cols_eff = 2'd1;
      else if (int'(cols_cfg) > MAX_PANEL_COLS)  cols_eff = 2'(MAX_PANEL_COLS);
      else                                       cols_eff = cols_cfg;
      regs_eff = {cols_eff, 1'b0};
   end

   assign last_k     = (k_ff == 2'd3);
   assign last_j     = (j_ff == REG_W'(regs_eff - 3'd1));
   assign last_n     = (n_ff == ROW_W'(rows_eff - 2'd1));
   assign last_issue = last_k & half_ff & last_j & last_n;

   assign s1_move   = s1_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign slot_free = ~s1_valid_ff | s1_move;

   assign status.slot_free  = slot_free;
   assign status.last_issue = last_issue;

   // write path
   assign wr_ok = (int'(req_data.panel_row) < MAX_PANEL_ROWS) &&
                  (int'(req_data.register_index) < REGS_PER_ROW);
   assign wr_addr = ADDR_W'((int'(req_data.panel_row) * REGS_PER_ROW
                             + int'(req_data.register_index)) * LINES_PER_REGISTER
                            + int'(req_data.line_index));

   // line of byte k is 12 + phase - 4k, modulo 16
   assign rd_addr = ADDR_W'((int'(n_ff) * REGS_PER_ROW + int'(j_ff)) * LINES_PER_REGISTER
                            + int'({~k_ff, phase_ff}));

   always_comb begin
      valid_in = valid_ff;
      if (cmd.write && wr_ok) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && wr_ok) begin
         mem[wr_addr] <= req_data.pixel_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         s1_word_ff  <= mem[rd_addr];
         s1_ok_ff    <= valid_ff[rd_addr];
         s1_half_ff  <= half_ff;
         s1_last_ff  <= last_issue;
         s1_phase_ff <= phase_ff;
      end
   end

   // run counters: byte, half, register, row
   always_comb begin
      k_in     = k_ff;
      half_in  = half_ff;
      j_in     = j_ff;
      n_in     = n_ff;
      phase_in = phase_ff;
      if (cmd.start) begin
         k_in    = '0;
         half_in = 1'b0;
         j_in    = '0;
         n_in    = '0;
      end else if (cmd.issue) begin
         k_in = k_ff + 2'd1;
         if (last_k) begin
            half_in = ~half_ff;
            if (half_ff) begin
               if (last_j) begin
                  j_in = '0;
                  n_in = n_ff + ROW_W'(1);
               end else begin
                  j_in = j_ff + REG_W'(1);
               end
            end
         end
         if (last_issue) begin
            phase_in = phase_ff + 2'd1;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (cmd.issue)    s1_valid_in = 1'b1;
      else if (s1_move) s1_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (s1_move)         out_valid_in = 1'b1;
      else if (!rsp_stall) out_valid_in = 1'b0;
   end

   assign s1_byte = ~(s1_ok_ff ? (s1_half_ff ? s1_word_ff[7:0] : s1_word_ff[15:8]) : 8'h00);

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_ff.spi_byte   <= s1_byte;
         out_ff.last       <= s1_last_ff;
         out_ff.row_select <= s1_last_ff ? s1_phase_ff : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      half_ff <= half_in;
      j_ff    <= j_in;
      n_ff    <= n_in;
      if (reset) begin
         valid_ff     <= '0;
         phase_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         phase_ff     <= phase_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && last_issue) |=> (phase_ff == $past(phase_ff) + 2'd1))
      else $error("scan phase did not advance after the final byte");

   a_no_write_in_run: assert property (@(posedge clock) disable iff (reset)
      !(cmd.write && (cmd.issue || cmd.start)))
      else $error("pixel write during a refresh run");

   a_issue_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (!s1_valid_ff || s1_move))
      else $error("read issued into an occupied stage");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (k_ff == 2'd0 && !half_ff && j_ff == '0 && n_ff == '0))
      else $error("run counters not cleared at start");

endmodule

/* rtl/led_matrix_quarter_scan_serializer_top.sv */
// Quarter-scan serializer for chained one-in-four multiplexed LED panels. A write
// transfer (mode 0) stores one 16-bit pixel word at (panel_row, register_index,
// line_index) in a 128-word pixel memory at default sizes; writes beyond the
// maximum rows or registers are dropped. A refresh transfer (mode 1) sends
// 8 * 2 * cols * rows bytes (16 to 64) for the current scan phase, high bytes then
// low bytes of lines 12+phase, 8+phase, 4+phase and phase of each register, all
// inverted; the final byte has last set and row_select equal to the phase sent,
// and the phase then steps on. The single read port of the pixel memory sets the
// pace: one byte per cycle unless rsp_stall backs up the output. Bytes pass the
// read stage and output register; the input stalls until a refresh's last read is
// issued. Memory words read as zero until written (one valid flop per word), so no
// clearing pass follows reset. panel_rows_used sits at address 0 and
// panel_cols_used at address 4; values of 0 act as 1 and values above the
// maximum act as the maximum. Write the registers only while the block is idle.
module led_matrix_quarter_scan_serializer_top #(
   parameter int MAX_PANEL_ROWS = 2,
   parameter int MAX_PANEL_COLS = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  lmqs_pkg::req_type               req_data,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output lmqs_pkg::rsp_type               rsp_data,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lmqs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lmqs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lmqs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import lmqs_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic [1:0]    rows_cfg;
   logic [1:0]    cols_cfg;

   // configuration registers
   lmqs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .rows_cfg    (rows_cfg),
      .cols_cfg    (cols_cfg)
   );

   // sequencer: takes transfers when idle, paces memory reads during a run
   lmqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // pixel memory, run counters, read stage and output register
   lmqs_datapath #(
      .MAX_PANEL_ROWS (MAX_PANEL_ROWS),
      .MAX_PANEL_COLS (MAX_PANEL_COLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rows_cfg  (rows_cfg),
      .cols_cfg  (cols_cfg),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/lmqs_scan_checker.sv */
module lmqs_scan_checker #(
   parameter int MAX_PANEL_ROWS = 2,
   parameter int MAX_PANEL_COLS = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  lmqs_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  lmqs_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lmqs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lmqs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                            csr_pready,
   output int                              fail_count,
   output int                              bytes_pending
);
   import lmqs_pkg::*;

   localparam int REGS_PER_ROW = 2 * MAX_PANEL_COLS;
   localparam int MEM_WORDS    = MAX_PANEL_ROWS * REGS_PER_ROW * LINES_PER_REGISTER;
   localparam int MAX_REPORTS  = 10;

   logic [15:0] pixel_shadow [MEM_WORDS];
   logic [1:0]  phase_shadow;
   logic [1:0]  rows_cfg;
   logic [1:0]  cols_cfg;
   rsp_type     expected_bytes [$];

   // zero counts as one, anything above the maximum as the maximum
   function automatic int effective_count(logic [1:0] v, int max_v);
      if (v == 2'd0) return 1;
      if (int'(v) > max_v) return max_v;
      return int'(v);
   endfunction

   // queue the inverted byte run of the current phase, then step the phase
   function automatic void queue_refresh_run();
      int          rows;
      int          regs;
      int          total;
      int          idx;
      int          base;
      int          ln;
      logic [15:0] word;
      rsp_type     b;
      rows  = effective_count(rows_cfg, MAX_PANEL_ROWS);
      regs  = 2 * effective_count(cols_cfg, MAX_PANEL_COLS);
      total = rows * regs * 8;
      idx   = 0;
      for (int n = 0; n < rows; n++) begin
         for (int j = 0; j < regs; j++) begin
            base = (n * REGS_PER_ROW + j) * LINES_PER_REGISTER;
            for (int half = 0; half < 2; half++) begin
               for (int k = 0; k < 4; k++) begin
                  ln   = 12 + int'(phase_shadow) - 4 * k;
                  word = pixel_shadow[base + ln];
                  b.spi_byte   = (half == 0) ? ~word[15:8] : ~word[7:0];
                  b.last       = (idx == total - 1);
                  b.row_select = (idx == total - 1) ? phase_shadow : 2'd0;
                  expected_bytes.push_back(b);
                  idx++;
               end
            end
         end
      end
      phase_shadow = phase_shadow + 2'd1;
   endfunction

   function automatic void check_byte(rsp_type got);
      rsp_type want;
      if (expected_bytes.size() == 0) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: byte with nothing expected: spi_byte %h last %b row_select %0d",
                     $time, got.spi_byte, got.last, got.row_select);
         return;
      end
      want = expected_bytes.pop_front();
      if (got.spi_byte !== want.spi_byte || got.last !== want.last ||
          got.row_select !== want.row_select) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: byte mismatch: exp spi_byte %h last %b row_select %0d, got %h %b %0d",
                     $time, want.spi_byte, want.last, want.row_select,
                     got.spi_byte, got.last, got.row_select);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < MEM_WORDS; a++) pixel_shadow[a] = '0;
         phase_shadow = '0;
         rows_cfg     = 2'd1;
         cols_cfg     = 2'd1;
         fail_count   = 0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_byte(rsp_data);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == CSR_IDX_ROWS) rows_cfg = csr_pwdata[1:0];
            else                              cols_cfg = csr_pwdata[1:0];
         end
         if (req_valid && !req_stall) begin
            if (req_data.mode == MODE_WRITE) begin
               // out-of-range addresses are dropped
               if (int'(req_data.panel_row) < MAX_PANEL_ROWS &&
                   int'(req_data.register_index) < REGS_PER_ROW)
                  pixel_shadow[(int'(req_data.panel_row) * REGS_PER_ROW +
                                int'(req_data.register_index)) * LINES_PER_REGISTER +
                               int'(req_data.line_index)] = req_data.pixel_word;
            end else begin
               queue_refresh_run();
            end
         end
      end
      bytes_pending = expected_bytes.size();
   end

endmodule

/* tb/tb_led_matrix_quarter_scan_serializer_top.sv */
module tb_led_matrix_quarter_scan_serializer_top;
   import lmqs_pkg::*;

   localparam int MAX_ROWS        = 2;
   localparam int MAX_COLS        = 2;
   // long receiver hold-off used to back the block up into its input
   localparam int RSP_HOLD_CYCLES = 400;
   // cycles with no transfer at all before the run is declared hung
   localparam int IDLE_LIMIT      = 4000;
   // quiet cycles after the last byte before the block counts as idle
   localparam int SETTLE_CYCLES   = 16;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 60;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ROWS = {CSR_IDX_ROWS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_COLS = {CSR_IDX_COLS, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int bytes_pending;
   int idle_cycles;

   // idling controls, changed per phase by the stimulus
   bit tx_gaps_on   = 1'b1;
   bit rsp_gaps_on  = 1'b1;
   bit rsp_hold_req = 1'b0;

   led_matrix_quarter_scan_serializer_top #(
      .MAX_PANEL_ROWS(MAX_ROWS),
      .MAX_PANEL_COLS(MAX_COLS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // watches both channels and the register port, predicts every byte
   lmqs_scan_checker #(
      .MAX_PANEL_ROWS(MAX_ROWS),
      .MAX_PANEL_COLS(MAX_COLS)
   ) scan_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .fail_count   (fail_count),
      .bytes_pending(bytes_pending)
   );

   // 8-unit clock, low half first so time zero is no rising edge
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // mostly zero or short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type write_item(logic row, logic [1:0] reg_idx,
                                          logic [3:0] line, logic [15:0] word);
      req_type it;
      it.mode           = MODE_WRITE;
      it.panel_row      = row;
      it.register_index = reg_idx;
      it.line_index     = line;
      it.pixel_word     = word;
      return it;
   endfunction

   // refresh tick; the address and data fields are don't-care and get noise
   function automatic req_type refresh_item();
      req_type it;
      it      = req_type'(24'($urandom));
      it.mode = MODE_REFRESH;
      return it;
   endfunction

   function automatic req_type random_write_item();
      req_type it;
      it      = req_type'(24'($urandom));
      it.mode = MODE_WRITE;
      return it;
   endfunction

   // offer one item, hold it until the transfer, then maybe idle
   task automatic send_item(input req_type it);
      int n;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      n = tx_gaps_on ? gap_length() : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // stop offering and wait for every predicted byte plus some slack
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (bytes_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup phase, access phase, then idle before the next access
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // reconfigure only once the block has gone quiet; upper data bits are noise
   task automatic set_panels(input logic [1:0] rows, input logic [1:0] cols);
      wait_drained();
      csr_write(ADDR_ROWS, {30'($urandom), rows});
      csr_write(ADDR_COLS, {30'($urandom), cols});
   endtask

   // receiver side: random stall bursts, or one long hold-off on request
   initial begin : rsp_side
      int n;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else begin
            n = rsp_gaps_on ? gap_length() : 0;
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // hang detector: any transfer on any port restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      // every input known from time zero
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset configuration: one row, one panel
      // untouched memory reads as zero, so every byte comes out all ones
      send_item(refresh_item());
      send_item(write_item(1'b0, 2'd0, 4'd15, 16'hFFFF));
      send_item(write_item(1'b0, 2'd0, 4'd0, 16'h0000));
      send_item(write_item(1'b0, 2'd1, 4'd12, 16'hA55A));
      send_item(write_item(1'b0, 2'd1, 4'd3, 16'h8001));
      send_item(write_item(1'b0, 2'd0, 4'd13, 16'hFF00));
      // beyond the configured counts: stored but not sent for now
      send_item(write_item(1'b1, 2'd3, 4'd15, 16'h1234));
      send_item(write_item(1'b1, 2'd2, 4'd0, 16'h00FF));
      // four ticks walk the phase through 1, 2, 3 and wrap back to 0
      repeat (4) send_item(refresh_item());

      // largest chain: the row 1 word written above at line 15 now shows up
      set_panels(2'd2, 2'd2);
      send_item(refresh_item());
      send_item(write_item(1'b1, 2'd3, 4'd14, 16'h0F0F));
      send_item(refresh_item());
      send_item(refresh_item());

      // zero counts act as one
      set_panels(2'd0, 2'd0);
      send_item(refresh_item());
      // counts above the maximum act as the maximum
      set_panels(2'd3, 2'd3);
      send_item(refresh_item());
      // mixed shapes
      set_panels(2'd1, 2'd2);
      send_item(refresh_item());
      set_panels(2'd2, 2'd1);
      send_item(refresh_item());

      // receiver holds off long while full-size runs keep coming
      set_panels(2'd2, 2'd2);
      tx_gaps_on   = 1'b0;
      rsp_hold_req = 1'b1;
      repeat (8) send_item(refresh_item());
      wait_drained();

      // random part: several settings, mostly pixel writes with random refresh ticks
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_panels(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
         // some phases run with no idling on one side
         tx_gaps_on  = (p % 3) != 0;
         rsp_gaps_on = (p % 4) != 1;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if ($urandom_range(0, 3) == 0) send_item(refresh_item());
            else                           send_item(random_write_item());
            // sender pauses now and then until every byte is out
            if ($urandom_range(0, 39) == 0) wait_drained();
         end
      end

      wait_drained();
      if (fail_count == 0 && bytes_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
